// File: sv/uvs_pkg.sv
package uvs_pkg;

  // field widths
  localparam int IN_W      = 5;
  localparam int IN_SPAN   = 2 ** IN_W;
  localparam int COORD_W   = 32;
  localparam int RADIUS_W  = 31;
  localparam int TRIG_W    = 31;
  localparam int PROD_W    = 62;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;

  // pipeline stages from first register after the cell hold to the output register
  localparam int PIPE_DEPTH = 6;

  // Q30 constants
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam logic [PROD_W-1:0] Q30_RND = PROD_W'(64'd536870912);

  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd65536;

  // register map
  typedef enum logic [1:0] {
    REG_CENTER_X,
    REG_CENTER_Y,
    REG_CENTER_Z,
    REG_SPHERE_RADIUS
  } reg_idx_t;

  typedef struct packed {
    logic [IN_W-1:0] lat_index;
    logic [IN_W-1:0] lon_index;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vert_a_x;
    logic signed [COORD_W-1:0] vert_a_y;
    logic signed [COORD_W-1:0] vert_a_z;
    logic signed [COORD_W-1:0] vert_b_x;
    logic signed [COORD_W-1:0] vert_b_y;
    logic signed [COORD_W-1:0] vert_b_z;
    logic signed [COORD_W-1:0] vert_c_x;
    logic signed [COORD_W-1:0] vert_c_y;
    logic signed [COORD_W-1:0] vert_c_z;
    logic                      last_triangle;
  } out_item_t;

  // sine and cosine as sign and Q30 magnitude
  typedef struct packed {
    logic              s_neg;
    logic [TRIG_W-1:0] s_mag;
    logic              c_neg;
    logic [TRIG_W-1:0] c_mag;
  } trig_t;

  typedef struct packed {
    logic [TRIG_W-1:0] s;
    logic [TRIG_W-1:0] c;
  } oct_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] center_x;
    logic signed [COORD_W-1:0] center_y;
    logic signed [COORD_W-1:0] center_z;
    logic [RADIUS_W-1:0]       radius;
  } sphere_cfg_t;

  // stage enables handed to each vertex datapath
  typedef struct packed {
    logic tab;
    logic mul;
    logic rnd;
    logic scl;
    logic out;
  } stage_en_t;

  // first-octant taylor series, truncating Q30 steps
  function automatic oct_t octant_sc(input logic [63:0] f);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    oct_t        o;
    x  = (f * Q30_HALF_PI + (Q30_ONE >> 1)) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    o.s = TRIG_W'((x * t) >> 30);
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd132;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd90;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd56;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd30;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd12;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd2;
    o.c = TRIG_W'(t);
    return o;
  endfunction

  // phase in units of one 2^32th of a turn, folded into the first octant
  function automatic trig_t sincos_phase(input logic [31:0] p);
    logic [63:0]       r;
    oct_t              oc;
    logic [TRIG_W-1:0] s0;
    logic [TRIG_W-1:0] c0;
    trig_t             o;
    r = {34'd0, p[29:0]};
    if (r <= (Q30_ONE >> 1)) begin
      oc = octant_sc(r);
      s0 = oc.s;
      c0 = oc.c;
    end else begin
      oc = octant_sc(Q30_ONE - r);
      s0 = oc.c;
      c0 = oc.s;
    end
    unique case (p[31:30])
      2'd0: begin
        o.s_neg = 1'b0; o.s_mag = s0; o.c_neg = 1'b0; o.c_mag = c0;
      end
      2'd1: begin
        o.s_neg = 1'b0; o.s_mag = c0; o.c_neg = 1'b1; o.c_mag = s0;
      end
      2'd2: begin
        o.s_neg = 1'b1; o.s_mag = s0; o.c_neg = 1'b1; o.c_mag = c0;
      end
      default: begin
        o.s_neg = 1'b1; o.s_mag = c0; o.c_neg = 1'b0; o.c_mag = s0;
      end
    endcase
    return o;
  endfunction

  // product magnitude back to Q30 / Q16, half rounded up
  function automatic logic [TRIG_W-1:0] round_q30(input logic [PROD_W-1:0] v);
    logic [PROD_W-1:0] s;
    s = v + Q30_RND;
    return s[60:30];
  endfunction

  // centre plus signed offset, saturated to 32 bits
  function automatic logic signed [COORD_W-1:0] add_sat(
    input logic signed [COORD_W-1:0] c,
    input logic                      neg,
    input logic [TRIG_W-1:0]         mag
  );
    logic signed [COORD_W:0] ce;
    logic signed [COORD_W:0] me;
    logic signed [COORD_W:0] s;
    logic signed [COORD_W-1:0] r;
    ce = {c[COORD_W-1], c};
    me = $signed({2'b00, mag});
    s  = neg ? (ce - me) : (ce + me);
    if (s[COORD_W] != s[COORD_W-1]) begin
      r = s[COORD_W] ? COORD_MIN : COORD_MAX;
    end else begin
      r = s[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: sv/uvs_vertex.sv
module uvs_vertex #(
  parameter int LAT_STEPS = 30,
  parameter int LON_STEPS = 25
) (
  input  logic                                clk,
  input  uvs_pkg::stage_en_t                  en,
  input  logic [$clog2(LAT_STEPS)-1:0]        lat_idx,
  input  logic [$clog2(LON_STEPS)-1:0]        lon_idx,
  input  uvs_pkg::sphere_cfg_t                cfg,
  output logic signed [uvs_pkg::COORD_W-1:0]  vx,
  output logic signed [uvs_pkg::COORD_W-1:0]  vy,
  output logic signed [uvs_pkg::COORD_W-1:0]  vz
);

  localparam int TW = uvs_pkg::TRIG_W;
  localparam int PW = uvs_pkg::PROD_W;

  uvs_pkg::trig_t lat_tab [LAT_STEPS];
  uvs_pkg::trig_t lon_tab [LON_STEPS];

  // latitude rom: u = i*pi/(LAT_STEPS-1)
  for (genvar g = 0; g < LAT_STEPS; g++) begin : g_lat
    localparam logic [63:0] PHASE =
      (64'(g) * 64'd2147483648 + 64'((LAT_STEPS - 1) / 2)) / 64'(LAT_STEPS - 1);
    assign lat_tab[g] = uvs_pkg::sincos_phase(PHASE[31:0]);
  end

  // longitude rom: v = j*2pi/LON_STEPS
  for (genvar g = 0; g < LON_STEPS; g++) begin : g_lon
    localparam logic [63:0] PHASE =
      (64'(g) * 64'd4294967296 + 64'(LON_STEPS / 2)) / 64'(LON_STEPS);
    assign lon_tab[g] = uvs_pkg::sincos_phase(PHASE[31:0]);
  end

  uvs_pkg::trig_t  tu_r;
  uvs_pkg::trig_t  tv_r;
  logic [PW-1:0]   px_r;
  logic [PW-1:0]   py_r;
  logic            nx3_r, ny3_r, nz3_r;
  logic [TW-1:0]   cz3_r;
  logic [TW-1:0]   mx_r, my_r, mz_r;
  logic            nx4_r, ny4_r, nz4_r;
  logic [PW-1:0]   qx_r, qy_r, qz_r;
  logic            nx5_r, ny5_r, nz5_r;
  logic signed [uvs_pkg::COORD_W-1:0] vx_r, vy_r, vz_r;

  // table read
  always_ff @(posedge clk) begin
    if (en.tab) begin
      tu_r <= lat_tab[lat_idx];
      tv_r <= lon_tab[lon_idx];
    end
  end

  // cos v * sin u and sin v * sin u
  always_ff @(posedge clk) begin
    if (en.mul) begin
      px_r  <= PW'(tv_r.c_mag) * PW'(tu_r.s_mag);
      py_r  <= PW'(tv_r.s_mag) * PW'(tu_r.s_mag);
      nx3_r <= tv_r.c_neg ^ tu_r.s_neg;
      ny3_r <= tv_r.s_neg ^ tu_r.s_neg;
      nz3_r <= tu_r.c_neg;
      cz3_r <= tu_r.c_mag;
    end
  end

  // round the direction back to Q30
  always_ff @(posedge clk) begin
    if (en.rnd) begin
      mx_r  <= uvs_pkg::round_q30(px_r);
      my_r  <= uvs_pkg::round_q30(py_r);
      mz_r  <= cz3_r;
      nx4_r <= nx3_r;
      ny4_r <= ny3_r;
      nz4_r <= nz3_r;
    end
  end

  // scale by the radius
  always_ff @(posedge clk) begin
    if (en.scl) begin
      qx_r  <= PW'(cfg.radius) * PW'(mx_r);
      qy_r  <= PW'(cfg.radius) * PW'(my_r);
      qz_r  <= PW'(cfg.radius) * PW'(mz_r);
      nx5_r <= nx4_r;
      ny5_r <= ny4_r;
      nz5_r <= nz4_r;
    end
  end

  // round to Q16, add the centre, saturate
  always_ff @(posedge clk) begin
    if (en.out) begin
      vx_r <= uvs_pkg::add_sat(cfg.center_x, nx5_r, uvs_pkg::round_q30(qx_r));
      vy_r <= uvs_pkg::add_sat(cfg.center_y, ny5_r, uvs_pkg::round_q30(qy_r));
      vz_r <= uvs_pkg::add_sat(cfg.center_z, nz5_r, uvs_pkg::round_q30(qz_r));
    end
  end

  assign vx = vx_r;
  assign vy = vy_r;
  assign vz = vz_r;

endmodule

// File: sv/uv_sphere_triangle_generator.sv
// an accepted cell passes the cell hold register and the pipeline stages on to the output
// throughput: one triangle per cycle through the output register while out_stall is low
// the hold register issues a cell's two triangles in turn, taking a new cell with the second
// reset: synchronous, active low; clears all valid bits, the centre to 0 and the radius to 1.0
// a stall on the output freezes only the stages behind a full one; bubbles close up
module uv_sphere_triangle_generator #(
  parameter int LAT_STEPS = 30,
  parameter int LON_STEPS = 25
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  uvs_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output uvs_pkg::out_item_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [uvs_pkg::CFG_AW-1:0]    paddr,
  input  logic [uvs_pkg::CFG_DW-1:0]    pwdata,
  output logic [uvs_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready
);

  localparam int LAT_IW = $clog2(LAT_STEPS);
  localparam int LON_IW = $clog2(LON_STEPS);
  localparam int DEPTH  = uvs_pkg::PIPE_DEPTH;

  // configuration registers
  logic signed [uvs_pkg::COORD_W-1:0] center_x_r, center_y_r, center_z_r;
  logic [uvs_pkg::RADIUS_W-1:0]       radius_r;
  uvs_pkg::reg_idx_t                  reg_idx;
  uvs_pkg::sphere_cfg_t               cfg;

  assign reg_idx = uvs_pkg::reg_idx_t'(paddr[3:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
      center_z_r <= '0;
      radius_r   <= uvs_pkg::RADIUS_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        uvs_pkg::REG_CENTER_X:      center_x_r <= pwdata;
        uvs_pkg::REG_CENTER_Y:      center_y_r <= pwdata;
        uvs_pkg::REG_CENTER_Z:      center_z_r <= pwdata;
        uvs_pkg::REG_SPHERE_RADIUS: radius_r   <= pwdata[uvs_pkg::RADIUS_W-1:0];
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (reg_idx)
      uvs_pkg::REG_CENTER_X:      prdata = center_x_r;
      uvs_pkg::REG_CENTER_Y:      prdata = center_y_r;
      uvs_pkg::REG_CENTER_Z:      prdata = center_z_r;
      uvs_pkg::REG_SPHERE_RADIUS: prdata = {1'b0, radius_r};
    endcase
  end

  assign cfg.center_x = center_x_r;
  assign cfg.center_y = center_y_r;
  assign cfg.center_z = center_z_r;
  assign cfg.radius   = radius_r;

  // index reduction tables for the narrow input fields
  logic [LAT_IW-1:0] lat_mod_tab [uvs_pkg::IN_SPAN];
  logic [LON_IW-1:0] lon_mod_tab [uvs_pkg::IN_SPAN];

  for (genvar g = 0; g < uvs_pkg::IN_SPAN; g++) begin : g_mod
    localparam int LAT_MOD = g % LAT_STEPS;
    localparam int LON_MOD = g % LON_STEPS;
    assign lat_mod_tab[g] = LAT_IW'(LAT_MOD);
    assign lon_mod_tab[g] = LON_IW'(LON_MOD);
  end

  logic [LAT_IW-1:0] i_in, i1_in;
  logic [LON_IW-1:0] j_in, j1_in;

  // neighbour indices wrap at the step counts, pole to pole included
  always_comb begin
    i_in  = lat_mod_tab[in_data.lat_index];
    j_in  = lon_mod_tab[in_data.lon_index];
    i1_in = (i_in == LAT_IW'(LAT_STEPS - 1)) ? '0 : i_in + LAT_IW'(1);
    j1_in = (j_in == LON_IW'(LON_STEPS - 1)) ? '0 : j_in + LON_IW'(1);
  end

  // stage enables: a stage loads when empty or when the next one loads
  logic [DEPTH:1] vld_r;
  logic [DEPTH:1] last_r;
  logic [DEPTH+1:1] stage_en;

  always_comb begin
    stage_en[DEPTH+1] = !out_stall;
    for (int k = DEPTH; k >= 1; k--) begin
      stage_en[k] = !vld_r[k] || stage_en[k+1];
    end
  end

  // cell hold register, issues triangle 0 then triangle 1
  logic              hold_v_r;
  logic              half_r;
  logic [LAT_IW-1:0] i_r, i1_r;
  logic [LON_IW-1:0] j_r, j1_r;
  logic              in_take;

  assign in_stall = hold_v_r && !(half_r && stage_en[1]);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      half_r   <= 1'b0;
    end else if (in_take) begin
      hold_v_r <= 1'b1;
      half_r   <= 1'b0;
    end else if (hold_v_r && stage_en[1]) begin
      hold_v_r <= !half_r;
      half_r   <= !half_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      i_r  <= i_in;
      i1_r <= i1_in;
      j_r  <= j_in;
      j1_r <= j1_in;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (stage_en[1]) begin
        vld_r[1] <= hold_v_r;
      end
      for (int k = 2; k <= DEPTH; k++) begin
        if (stage_en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // last-triangle flag travels with the valid bits
  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      last_r[1] <= half_r;
    end
    for (int k = 2; k <= DEPTH; k++) begin
      if (stage_en[k]) begin
        last_r[k] <= last_r[k-1];
      end
    end
  end

  // vertex index selection for the current triangle
  logic [LAT_IW-1:0] a_lat_r, b_lat_r, c_lat_r;
  logic [LON_IW-1:0] a_lon_r, b_lon_r, c_lon_r;

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      a_lat_r <= i_r;
      a_lon_r <= half_r ? j1_r : j_r;
      b_lat_r <= i1_r;
      b_lon_r <= j_r;
      c_lat_r <= half_r ? i1_r : i_r;
      c_lon_r <= j1_r;
    end
  end

  uvs_pkg::stage_en_t ven;

  assign ven.tab = stage_en[2];
  assign ven.mul = stage_en[3];
  assign ven.rnd = stage_en[4];
  assign ven.scl = stage_en[5];
  assign ven.out = stage_en[6];

  // three vertex datapaths in lockstep
  uvs_vertex #(
    .LAT_STEPS (LAT_STEPS),
    .LON_STEPS (LON_STEPS)
  ) u_vert_a (
    .clk     (clk),
    .en      (ven),
    .lat_idx (a_lat_r),
    .lon_idx (a_lon_r),
    .cfg     (cfg),
    .vx      (out_data.vert_a_x),
    .vy      (out_data.vert_a_y),
    .vz      (out_data.vert_a_z)
  );

  uvs_vertex #(
    .LAT_STEPS (LAT_STEPS),
    .LON_STEPS (LON_STEPS)
  ) u_vert_b (
    .clk     (clk),
    .en      (ven),
    .lat_idx (b_lat_r),
    .lon_idx (b_lon_r),
    .cfg     (cfg),
    .vx      (out_data.vert_b_x),
    .vy      (out_data.vert_b_y),
    .vz      (out_data.vert_b_z)
  );

  uvs_vertex #(
    .LAT_STEPS (LAT_STEPS),
    .LON_STEPS (LON_STEPS)
  ) u_vert_c (
    .clk     (clk),
    .en      (ven),
    .lat_idx (c_lat_r),
    .lon_idx (c_lon_r),
    .cfg     (cfg),
    .vx      (out_data.vert_c_x),
    .vy      (out_data.vert_c_y),
    .vz      (out_data.vert_c_z)
  );

  assign out_data.last_triangle = last_r[DEPTH];
  assign out_valid              = vld_r[DEPTH];

endmodule

// File: sv/uvs_checker.sv
module uvs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input uvs_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // the second triangle of a cell follows the first without a gap
  a_pair_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_triangle |=>
      out_valid && out_data.last_triangle)
    else $error("second triangle of a cell not ready behind the first");

  // a last triangle is never followed directly by another last triangle
  a_pair_alternate: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last_triangle |=>
      !out_valid || !out_data.last_triangle)
    else $error("two last triangles in a row");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind uv_sphere_triangle_generator uvs_checker u_uvs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
